// ===== rtl/jpps_pkg.sv =====
package jpps_pkg;

    localparam int POOL_DEPTH = 32;
    localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
    localparam int IDX_W      = $clog2(POOL_DEPTH);

    localparam int ID_W   = 10;
    localparam int PRIO_W = 8;
    localparam int WORD_W = 10;
    localparam int SIZE_W = 12;
    localparam int DISK_W = 11;
    localparam int WAIT_W = 6;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_SELECT = 1'b1;

    localparam logic [1:0] POL_FCFS = 2'd0;
    localparam logic [1:0] POL_PRIO = 2'd1;
    localparam logic [1:0] POL_SIZE = 2'd2;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_SELECTED = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [SIZE_W-1:0] size;
        logic [DISK_W-1:0] disk;
    } entry_t;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

endpackage

// ===== rtl/jpps_if.sv =====
interface jpps_cfg_if import jpps_pkg::*;;
    logic       valid;
    logic       ready;
    logic [1:0] policy;

    modport source (output valid, output policy, input ready);
    modport sink   (input valid, input policy, output ready);
endinterface

interface jpps_req_if import jpps_pkg::*;;
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [ID_W-1:0]   job_id;
    logic [PRIO_W-1:0] job_priority;
    logic [WORD_W-1:0] code_words;
    logic [WORD_W-1:0] input_words;
    logic [WORD_W-1:0] output_words;
    logic [WORD_W-1:0] temp_words;
    logic [DISK_W-1:0] disk_base;

    modport source (output valid, output req_type, output job_id, output job_priority,
                    output code_words, output input_words, output output_words,
                    output temp_words, output disk_base, input ready);
    modport sink   (input valid, input req_type, input job_id, input job_priority,
                    input code_words, input input_words, input output_words,
                    input temp_words, input disk_base, output ready);
endinterface

interface jpps_rsp_if import jpps_pkg::*;;
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [ID_W-1:0]   sel_id;
    logic [PRIO_W-1:0] sel_priority;
    logic [SIZE_W-1:0] sel_size;
    logic [DISK_W-1:0] sel_disk_base;
    logic [WAIT_W-1:0] waiting_count;

    modport source (output valid, output status, output sel_id, output sel_priority,
                    output sel_size, output sel_disk_base, output waiting_count,
                    input ready);
    modport sink   (input valid, input status, input sel_id, input sel_priority,
                    input sel_size, input sel_disk_base, input waiting_count,
                    output ready);
endinterface

// ===== rtl/jpps_cell.sv =====
module jpps_cell import jpps_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  entry_t     load_data,
    input  entry_t     next_data,
    output entry_t     data
);

    entry_t data_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            data_reg <= load_data;
        end
        else if (ctrl.shift)
        begin
            data_reg <= next_data;
        end
    end

    assign data = data_reg;

endmodule

// ===== rtl/job_pool_policy_selector_unit.sv =====
// Job pool held in a row of cells in arrival order. An insert word writes
// the job into the cell at the tail, or reports full if the pool is full; a
// select on an empty pool reports empty. A select under first-come (or an
// unused policy code) or with one job waiting takes the head job; under
// priority or size policy the pick walks the cells one per cycle holding
// the best candidate, then the picked cell and every cell past it load from
// their neighbors together to close the gap. One word is in work at a time;
// a finished result waits in the output register while the next word is
// accepted. The policy register takes writes at any time it is idle.
module job_pool_policy_selector_unit import jpps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    jpps_cfg_if.sink    cfg,
    jpps_req_if.sink    req,
    jpps_rsp_if.source  rsp
);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SHIFT, S_EMIT} state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [IDX_W-1:0]  scan_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    entry_t            best_reg;
    logic [1:0]        policy_reg;
    logic [1:0]        res_status_reg;
    logic              res_sel_reg;

    logic              out_valid_reg;
    logic [1:0]        out_status_reg;
    entry_t            out_entry_reg;
    logic [WAIT_W-1:0] out_wait_reg;

    entry_t            cell_q [POOL_DEPTH];
    cell_ctrl_t        ctrl   [POOL_DEPTH];

    logic              accept;
    logic              is_ins;
    logic              full;
    logic              ins_go;
    logic              shift_go;
    logic              emit_go;
    logic              keyed;
    entry_t            new_entry;
    entry_t            scan_entry;
    logic [SIZE_W-1:0] scan_key;
    logic [SIZE_W-1:0] best_key;

    function automatic logic [SIZE_W-1:0] key_of(entry_t e, logic [1:0] pol);
        logic [SIZE_W-1:0] k;
        if (pol == POL_PRIO)
        begin
            k = SIZE_W'(e.prio);
        end
        else
        begin
            k = e.size;
        end
        return k;
    endfunction

    assign cfg.ready = (state_reg == S_IDLE);
    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign is_ins    = (req.req_type == REQ_INSERT);
    assign full      = (count_reg == CNT_W'(POOL_DEPTH));
    assign ins_go    = accept && is_ins && !full;
    assign shift_go  = (state_reg == S_SHIFT);
    assign emit_go   = (state_reg == S_EMIT) && (!out_valid_reg || rsp.ready);
    assign keyed     = (policy_reg == POL_PRIO) || (policy_reg == POL_SIZE);

    always_comb
    begin
        new_entry.id   = req.job_id;
        new_entry.prio = req.job_priority;
        new_entry.size = SIZE_W'(req.code_words) + SIZE_W'(req.input_words)
                       + SIZE_W'(req.output_words) + SIZE_W'(req.temp_words);
        new_entry.disk = req.disk_base;
    end

    assign scan_entry = cell_q[scan_reg];
    assign scan_key   = key_of(scan_entry, policy_reg);
    assign best_key   = key_of(best_reg, policy_reg);

    for (genvar i = 0; i < POOL_DEPTH; i++)
    begin : g_cell
        localparam logic [CNT_W-1:0] POS      = CNT_W'(i);
        localparam logic [CNT_W-1:0] POS_NEXT = CNT_W'(i + 1);
        entry_t next_data;

        if (i == POOL_DEPTH - 1)
        begin : g_last
            assign next_data = '0;
        end
        else
        begin : g_mid
            assign next_data = cell_q[i + 1];
        end

        assign ctrl[i].load  = ins_go && (count_reg == POS);
        assign ctrl[i].shift = shift_go && (POS >= CNT_W'(best_idx_reg))
                             && (POS_NEXT < count_reg);

        jpps_cell u_cell
        (
            .clk       (clk),
            .ctrl      (ctrl[i]),
            .load_data (new_entry),
            .next_data (next_data),
            .data      (cell_q[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            policy_reg     <= POL_FCFS;
            out_valid_reg  <= 1'b0;
            scan_reg       <= '0;
            best_idx_reg   <= '0;
            best_reg       <= '0;
            res_status_reg <= ST_INSERTED;
            res_sel_reg    <= 1'b0;
            out_status_reg <= ST_INSERTED;
            out_entry_reg  <= '0;
            out_wait_reg   <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                policy_reg <= cfg.policy;
            end
            if (rsp.valid && rsp.ready && !emit_go)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        res_sel_reg <= 1'b0;
                        if (is_ins)
                        begin
                            state_reg <= S_EMIT;
                            if (full)
                            begin
                                res_status_reg <= ST_FULL;
                            end
                            else
                            begin
                                res_status_reg <= ST_INSERTED;
                                count_reg      <= count_reg + CNT_W'(1);
                            end
                        end
                        else if (count_reg == '0)
                        begin
                            res_status_reg <= ST_EMPTY;
                            state_reg      <= S_EMIT;
                        end
                        else
                        begin
                            best_idx_reg <= '0;
                            best_reg     <= cell_q[0];
                            scan_reg     <= IDX_W'(1);
                            if (keyed && (count_reg > CNT_W'(1)))
                            begin
                                state_reg <= S_SCAN;
                            end
                            else
                            begin
                                state_reg <= S_SHIFT;
                            end
                        end
                    end
                end
                S_SCAN:
                begin
                    if (scan_key < best_key)
                    begin
                        best_reg     <= scan_entry;
                        best_idx_reg <= scan_reg;
                    end
                    if (CNT_W'(scan_reg) == count_reg - CNT_W'(1))
                    begin
                        state_reg <= S_SHIFT;
                    end
                    else
                    begin
                        scan_reg <= scan_reg + IDX_W'(1);
                    end
                end
                S_SHIFT:
                begin
                    count_reg      <= count_reg - CNT_W'(1);
                    res_status_reg <= ST_SELECTED;
                    res_sel_reg    <= 1'b1;
                    state_reg      <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (emit_go)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= res_status_reg;
                        out_entry_reg  <= res_sel_reg ? best_reg : '0;
                        out_wait_reg   <= WAIT_W'(count_reg);
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.sel_id        = out_entry_reg.id;
    assign rsp.sel_priority  = out_entry_reg.prio;
    assign rsp.sel_size      = out_entry_reg.size;
    assign rsp.sel_disk_base = out_entry_reg.disk;
    assign rsp.waiting_count = out_wait_reg;

endmodule

// ===== sim/jpps_checker.sv =====
module jpps_checker import jpps_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    jpps_cfg_if  cfg,
    jpps_req_if  req,
    jpps_rsp_if  rsp,
    output int   mismatches,
    output int   outstanding,
    output int   words_checked,
    output int   full_drops,
    output int   empty_selects
);

    typedef struct packed {
        logic [1:0]        status;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [SIZE_W-1:0] size;
        logic [DISK_W-1:0] disk;
        logic [WAIT_W-1:0] waiting;
    } pool_result_t;

    entry_t       pool_model [POOL_DEPTH];
    int           pool_count = 0;
    logic [1:0]   policy_model = POL_FCFS;
    pool_result_t expected_results [$];
    int           fails = 0;
    int           checked = 0;
    int           fulls = 0;
    int           empties = 0;

    function automatic int pick_slot();
        int best;
        int i;
        best = 0;
        for (i = 1; i < pool_count; i++)
        begin
            if (policy_model == POL_PRIO && pool_model[i].prio < pool_model[best].prio)
                best = i;
            else if (policy_model == POL_SIZE && pool_model[i].size < pool_model[best].size)
                best = i;
        end
        return best;
    endfunction

    task automatic predict_request();
        pool_result_t r;
        int           k;
        int           i;
        r = '0;
        if (req.req_type == REQ_INSERT)
        begin
            if (pool_count >= POOL_DEPTH)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                pool_model[pool_count].id   = req.job_id;
                pool_model[pool_count].prio = req.job_priority;
                pool_model[pool_count].size = SIZE_W'(req.code_words) + SIZE_W'(req.input_words)
                                            + SIZE_W'(req.output_words) + SIZE_W'(req.temp_words);
                pool_model[pool_count].disk = req.disk_base;
                pool_count++;
                r.status = ST_INSERTED;
            end
        end
        else if (pool_count == 0)
        begin
            r.status = ST_EMPTY;
        end
        else
        begin
            k = pick_slot();
            r.id   = pool_model[k].id;
            r.prio = pool_model[k].prio;
            r.size = pool_model[k].size;
            r.disk = pool_model[k].disk;
            for (i = k; i + 1 < pool_count; i++)
                pool_model[i] = pool_model[i + 1];
            pool_count--;
            r.status = ST_SELECTED;
        end
        r.waiting = WAIT_W'(pool_count);
        expected_results.push_back(r);
    endtask

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, exp_val, act_val);
            fails++;
        end
    endtask

    task automatic check_result();
        pool_result_t e;
        if (expected_results.size() == 0)
        begin
            $display("%0t: result word with nothing expected, actual status %0d id %0d",
                     $time, rsp.status, rsp.sel_id);
            fails++;
        end
        else
        begin
            e = expected_results.pop_front();
            check_field("status", e.status, rsp.status);
            check_field("sel_id", e.id, rsp.sel_id);
            check_field("sel_priority", e.prio, rsp.sel_priority);
            check_field("sel_size", e.size, rsp.sel_size);
            check_field("sel_disk_base", e.disk, rsp.sel_disk_base);
            check_field("waiting_count", e.waiting, rsp.waiting_count);
            if (e.status == ST_FULL)
                fulls++;
            if (e.status == ST_EMPTY)
                empties++;
            checked++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_count   = 0;
            policy_model = POL_FCFS;
            expected_results.delete();
        end
        else
        begin
            if (rsp.valid && rsp.ready)
                check_result();
            if (cfg.valid && cfg.ready)
                policy_model = cfg.policy;
            if (req.valid && req.ready)
                predict_request();
        end
        mismatches    <= fails;
        outstanding   <= expected_results.size();
        words_checked <= checked;
        full_drops    <= fulls;
        empty_selects <= empties;
    end

endmodule

// ===== sim/tb_job_pool_policy_selector_unit.sv =====
module tb_job_pool_policy_selector_unit;
    import jpps_pkg::*;

    localparam logic [1:0] POL_SPARE = 2'd3;
    localparam int PHASES     = 11;
    localparam int PHASE_LEN  = 150;

    typedef struct {
        logic              req_type;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [WORD_W-1:0] code;
        logic [WORD_W-1:0] inw;
        logic [WORD_W-1:0] outw;
        logic [WORD_W-1:0] tmp;
        logic [DISK_W-1:0] disk;
    } job_word_t;

    logic clk = 1'b0;
    logic rst_n;

    int mismatches;
    int outstanding;
    int words_checked;
    int full_drops;
    int empty_selects;
    int words_sent = 0;
    int burst_left = 0;

    jpps_cfg_if cfg_ch ();
    jpps_req_if req_ch ();
    jpps_rsp_if rsp_ch ();

    job_pool_policy_selector_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    jpps_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_ch),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .words_checked (words_checked),
        .full_drops    (full_drops),
        .empty_selects (empty_selects)
    );

    always #2 clk = ~clk;

    function automatic job_word_t make_job(input int id, input int prio, input int c,
                                           input int i, input int o, input int t,
                                           input int disk);
        job_word_t w;
        w.req_type = REQ_INSERT;
        w.id       = ID_W'(id);
        w.prio     = PRIO_W'(prio);
        w.code     = WORD_W'(c);
        w.inw      = WORD_W'(i);
        w.outw     = WORD_W'(o);
        w.tmp      = WORD_W'(t);
        w.disk     = DISK_W'(disk);
        return w;
    endfunction

    function automatic job_word_t rand_word(input int insert_pct, input bit narrow);
        job_word_t w;
        w.req_type = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_SELECT;
        w.id       = ID_W'($urandom);
        w.disk     = DISK_W'($urandom);
        w.prio     = narrow ? PRIO_W'($urandom_range(0, 3)) : PRIO_W'($urandom);
        w.code     = narrow ? WORD_W'($urandom_range(0, 2)) : WORD_W'($urandom);
        w.inw      = narrow ? WORD_W'($urandom_range(0, 2)) : WORD_W'($urandom);
        w.outw     = narrow ? WORD_W'($urandom_range(0, 2)) : WORD_W'($urandom);
        w.tmp      = narrow ? WORD_W'($urandom_range(0, 2)) : WORD_W'($urandom);
        return w;
    endfunction

    function automatic job_word_t pick_word();
        job_word_t w;
        w = rand_word(0, 1'b0);
        return w;
    endfunction

    task automatic offer_word(input job_word_t w);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 12);
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= w.req_type;
        req_ch.job_id       <= w.id;
        req_ch.job_priority <= w.prio;
        req_ch.code_words   <= w.code;
        req_ch.input_words  <= w.inw;
        req_ch.output_words <= w.outw;
        req_ch.temp_words   <= w.tmp;
        req_ch.disk_base    <= w.disk;
        do @(posedge clk); while (!req_ch.ready);
        burst_left--;
        words_sent++;
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_policy(input logic [1:0] p);
        cfg_ch.valid  <= 1'b1;
        cfg_ch.policy <= p;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            int mode;
            int stretch;
            int cycles;
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(10, 80);
            repeat (stretch)
            begin
                case (mode)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= ($urandom_range(0, 9) < 7);
                    2:       rsp_ch.ready <= (cycles % 3 == 0);
                    default: rsp_ch.ready <= ($urandom_range(0, 9) < 2);
                endcase
                @(posedge clk);
                cycles++;
                if (cycles == 1500 || cycles == 12000)
                begin
                    rsp_ch.ready <= 1'b0;
                    repeat (400) @(posedge clk);
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        logic [1:0] phase_policy [PHASES];
        int         phase_insert [PHASES];
        int         ph;
        int         n;

        phase_policy = '{POL_FCFS, POL_PRIO, POL_SIZE, POL_SPARE, POL_PRIO, POL_SIZE,
                         POL_FCFS, POL_SIZE, POL_PRIO, POL_SPARE, POL_PRIO};
        phase_insert = '{95, 50, 70, 40, 85, 60, 30, 90, 55, 65, 20};

        rst_n               <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.policy       <= POL_FCFS;
        req_ch.valid        <= 1'b0;
        req_ch.req_type     <= REQ_INSERT;
        req_ch.job_id       <= '0;
        req_ch.job_priority <= '0;
        req_ch.code_words   <= '0;
        req_ch.input_words  <= '0;
        req_ch.output_words <= '0;
        req_ch.temp_words   <= '0;
        req_ch.disk_base    <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        offer_word(pick_word());
        offer_word(make_job(0, 0, 0, 0, 0, 0, 0));
        offer_word(make_job(1023, 255, 1023, 1023, 1023, 1023, 2047));
        offer_word(pick_word());
        offer_word(pick_word());
        offer_word(pick_word());
        drain();

        write_policy(POL_PRIO);
        offer_word(make_job(11, 5, 10, 0, 0, 0, 100));
        offer_word(make_job(12, 2, 20, 0, 0, 0, 200));
        offer_word(make_job(13, 2, 5, 0, 0, 0, 300));
        offer_word(make_job(14, 255, 1, 0, 0, 0, 400));
        repeat (4) offer_word(pick_word());
        drain();

        write_policy(POL_SIZE);
        offer_word(make_job(21, 9, 50, 50, 0, 0, 1));
        offer_word(make_job(22, 8, 3, 4, 0, 0, 2));
        offer_word(make_job(23, 7, 0, 0, 7, 0, 3));
        offer_word(make_job(24, 6, 1023, 1023, 1023, 1023, 4));
        repeat (4) offer_word(pick_word());
        drain();

        write_policy(POL_SPARE);
        offer_word(make_job(31, 0, 1023, 0, 0, 0, 5));
        offer_word(make_job(32, 1, 0, 0, 0, 0, 6));
        offer_word(pick_word());
        offer_word(pick_word());
        drain();

        for (ph = 0; ph < PHASES; ph++)
        begin
            write_policy(phase_policy[ph]);
            for (n = 0; n < PHASE_LEN; n++)
                offer_word(rand_word(phase_insert[ph], ph % 2 == 1));
            drain();
        end

        repeat (40) @(posedge clk);
        $display("covered: %0d request words, %0d results checked, %0d full drops, %0d empty selects",
                 words_sent, words_checked, full_drops, empty_selects);
        $display("policies first come, priority, size and the spare code, with ties and a full pool");
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/jpps_pkg.sv
rtl/jpps_if.sv
rtl/jpps_cell.sv
rtl/job_pool_policy_selector_unit.sv
sim/jpps_checker.sv
sim/tb_job_pool_policy_selector_unit.sv
